[rtl/ttu_pkg.sv]
// package: widths, constants, codes and state type for the tick to microsecond converter
`default_nettype none
package ttu_pkg;

    localparam int SAMPLE_W = 64;
    localparam int HALF_W   = 32;
    localparam int USEC_W   = 32;
    localparam int FREQ_W   = 32;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = HALF_W + SCALE_W;
    localparam int CNT_W    = $clog2(PROD_W);

    localparam logic [SCALE_W-1:0] USEC_PER_SECOND = SCALE_W'(1000000);
    localparam logic [FREQ_W-1:0]  FREQ_RESET      = FREQ_W'(3579545);

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_LO,
        ST_SUB_HI,
        ST_MUL,
        ST_DIV,
        ST_ACC
    } state_t;

endpackage
`default_nettype wire

[rtl/ttu_if.sv]
// interfaces: sample input channel and microsecond result channel
`default_nettype none
interface ttu_in_if;
    import ttu_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [SAMPLE_W-1:0] counter_sample;

    modport source (output valid, output command, output counter_sample, input ready);
    modport sink   (input valid, input command, input counter_sample, output ready);
endinterface

interface ttu_out_if;
    import ttu_pkg::*;

    logic              valid;
    logic              ready;
    logic [USEC_W-1:0] microseconds;

    modport source (output valid, output microseconds, input ready);
    modport sink   (input valid, input microseconds, output ready);
endinterface
`default_nettype wire

[rtl/ticks_to_microseconds_accumulator_top.sv]
// top level: tick counter samples to a running microsecond total, bit-serial divider
//
// Each input transaction carries a command and a 64-bit counter sample. A start
// latches the sample, clears the total and the fraction, and yields a result of
// zero. A sample forms the 64-bit difference from the last sample in two 32-bit
// halves (borrow carried between them), clamps it to 0xFFFFFFFF when the upper
// half is nonzero, scales it by one million in a single 32x20 multiply, then
// divides the 52-bit product by tick_frequency with a restoring divider that
// retires one quotient bit per cycle. Quotient and remainder are then folded
// into the total and the fraction, with a single carry when the fraction
// reaches the frequency. A sample passes through the low and high subtract,
// the multiply, 52 divide steps and the accumulate, in that order. With
// tick_frequency at zero the divide is skipped and the total is returned
// unchanged. The block works on one transaction at a time and only accepts
// input when idle; the result sits in an output register, so a new transaction
// may be taken while the previous result is still waiting. tick_frequency is
// written through cfg_write_enable / cfg_write_data; the user must write it
// only while idle, as the block itself does not enforce this.
`default_nettype none
module ticks_to_microseconds_accumulator_top (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_write_enable,
    input  wire [ttu_pkg::FREQ_W-1:0]  cfg_write_data,
    ttu_in_if.sink                     in_ch,
    ttu_out_if.source                  out_ch
);
    import ttu_pkg::*;

    // control state
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic                  skip_reg;

    // configuration and accumulators
    logic [FREQ_W-1:0]     freq_reg;
    logic [SAMPLE_W-1:0]   last_count_reg;
    logic [USEC_W-1:0]     total_reg;
    logic [FREQ_W-1:0]     frac_reg;

    // working registers for one transaction
    logic                  cmd_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [HALF_W-1:0]     delta_lo_reg;
    logic                  borrow_reg;
    logic [HALF_W-1:0]     ticks_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [FREQ_W-1:0]     rem_reg;
    logic [USEC_W-1:0]     quot_reg;
    logic [USEC_W-1:0]     out_data_reg;

    // handshake strobes
    logic                  in_fire;
    logic                  acc_fire;

    // combinational datapath
    logic [HALF_W:0]       sub_lo;
    logic [HALF_W-1:0]     sub_hi;
    logic [FREQ_W:0]       div_trial;
    logic                  div_take;
    logic [FREQ_W:0]       frac_sum;
    logic                  frac_carry;
    logic [USEC_W-1:0]     total_sum;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (in_ch.command == CMD_START) ? ST_ACC : ST_SUB_LO;
                end
            end
            ST_SUB_LO: state_next = ST_SUB_HI;
            ST_SUB_HI: state_next = ST_MUL;
            ST_MUL:    state_next = (freq_reg == '0) ? ST_ACC : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (acc_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        acc_fire    = (state_reg == ST_ACC) && (!out_valid_reg || out_ch.ready);
    end

    assign in_fire             = in_ch.valid && in_ch.ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.microseconds = out_data_reg;

    // ---------------------------------------------------------------- arithmetic
    // low half difference with borrow out in the top bit
    assign sub_lo = {1'b0, sample_reg[HALF_W-1:0]} - {1'b0, last_count_reg[HALF_W-1:0]};
    assign sub_hi = sample_reg[SAMPLE_W-1:HALF_W] - last_count_reg[SAMPLE_W-1:HALF_W]
                    - HALF_W'(borrow_reg);

    // one restoring divide step: bring down the next product bit
    assign div_trial = {rem_reg, prod_reg[PROD_W-1]};
    assign div_take  = (div_trial >= {1'b0, freq_reg});

    // fold remainder into the fraction, carry at most once
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, rem_reg};
    assign frac_carry = (frac_sum >= {1'b0, freq_reg});
    assign total_sum  = total_reg + quot_reg + USEC_W'(frac_carry);

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            freq_reg       <= FREQ_RESET;
            last_count_reg <= '0;
            total_reg      <= '0;
            frac_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_enable)
            begin
                freq_reg <= cfg_write_data;
            end

            if (state_reg == ST_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (acc_fire)
            begin
                out_valid_reg  <= 1'b1;
                last_count_reg <= sample_reg;
                if (cmd_reg == CMD_START)
                begin
                    total_reg <= '0;
                    frac_reg  <= '0;
                end
                else if (!skip_reg)
                begin
                    total_reg <= total_sum;
                    frac_reg  <= frac_carry ? FREQ_W'(frac_sum - {1'b0, freq_reg})
                                            : frac_sum[FREQ_W-1:0];
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_reg    <= in_ch.command;
                    sample_reg <= in_ch.counter_sample;
                end
            end
            ST_SUB_LO:
            begin
                delta_lo_reg <= sub_lo[HALF_W-1:0];
                borrow_reg   <= sub_lo[HALF_W];
            end
            ST_SUB_HI:
            begin
                // clamp large differences
                ticks_reg <= (sub_hi != '0) ? '1 : delta_lo_reg;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(ticks_reg) * PROD_W'(USEC_PER_SECOND);
                rem_reg  <= '0;
                quot_reg <= '0;
                skip_reg <= (freq_reg == '0);
            end
            ST_DIV:
            begin
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                rem_reg  <= div_take ? FREQ_W'(div_trial - {1'b0, freq_reg})
                                     : div_trial[FREQ_W-1:0];
                // only the low quotient bits are kept
                quot_reg <= {quot_reg[USEC_W-2:0], div_take};
            end
            ST_ACC:
            begin
                if (acc_fire)
                begin
                    if (cmd_reg == CMD_START)
                    begin
                        out_data_reg <= '0;
                    end
                    else if (skip_reg)
                    begin
                        out_data_reg <= total_reg;
                    end
                    else
                    begin
                        out_data_reg <= total_sum;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- assertions
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("block still idle after accepting a transaction");

    a_result_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_ACC))
        else $error("result raised outside the accumulate step");

    a_start_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_fire && (cmd_reg == CMD_START)) |=> (out_data_reg == '0) && (total_reg == '0))
        else $error("start did not clear the total");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(PROD_W - 1)))
        else $error("divider step count out of range");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// testbench for the tick to microsecond accumulator: directed, random and back-pressure runs
`timescale 1ns / 100ps
module tb_top;
    import ttu_pkg::*;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    // long receiver hold-off, well past one full sample computation
    localparam int HOLD_CYCLES   = 300;
    // quiet time after the last result, about one sample latency
    localparam int SETTLE_CYCLES = 64;

    logic              clk              = 1'b0;
    logic              rst_n            = 1'b0;
    logic              cfg_write_enable = 1'b0;
    logic [FREQ_W-1:0] cfg_write_data   = '0;

    ttu_in_if  in_ch ();
    ttu_out_if out_ch ();

    ticks_to_microseconds_accumulator_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_ch            (in_ch),
        .out_ch           (out_ch)
    );

    always #1 clk = ~clk;

    // random idling on both sides, switched off for the closing stretch
    bit idle_on   = 1'b1;
    // receiver hold-off request, counted down by the receiver process
    int hold_left = 0;

    int failure_count = 0;
    int quiet_cycles  = 0;

    // predicted copy of the converter state and its frequency register
    logic [FREQ_W-1:0]   pred_freq       = FREQ_RESET;
    logic [SAMPLE_W-1:0] pred_last_count = '0;
    logic [USEC_W-1:0]   pred_total      = '0;
    logic [USEC_W-1:0]   pred_fraction   = '0;

    // microsecond totals still owed by the block, oldest first
    logic [USEC_W-1:0]   expected_usec_q[$];

    // advance the predicted state by one accepted transaction, return the new total
    function automatic logic [USEC_W-1:0] advance_usec_total(input cmd_t cmd,
                                                            input logic [SAMPLE_W-1:0] count);
        logic [SAMPLE_W-1:0] delta;
        logic [HALF_W-1:0]   ticks;
        logic [63:0]         scaled;
        logic [63:0]         quot;
        logic [63:0]         rem;
        logic [HALF_W:0]     frac_sum;
        logic [USEC_W-1:0]   total;
        if (cmd == CMD_START)
        begin
            pred_last_count = count;
            pred_total      = '0;
            pred_fraction   = '0;
            return '0;
        end
        // modulo 2^64 difference, so a counter wrap comes out small
        delta           = count - pred_last_count;
        pred_last_count = count;
        // anything past 32 bits of ticks saturates
        ticks = (delta[SAMPLE_W-1:HALF_W] != '0) ? '1 : delta[HALF_W-1:0];
        // a zero frequency freezes total and fraction
        if (pred_freq != '0)
        begin
            scaled   = 64'(USEC_PER_SECOND) * 64'(ticks);
            quot     = scaled / 64'(pred_freq);
            rem      = scaled % 64'(pred_freq);
            // 33-bit sum, at most one carry into the total
            frac_sum = {1'b0, pred_fraction} + rem[HALF_W:0];
            total    = pred_total + quot[USEC_W-1:0];
            if (frac_sum >= {1'b0, pred_freq})
            begin
                total    = total + USEC_W'(1);
                frac_sum = frac_sum - {1'b0, pred_freq};
            end
            pred_total    = total;
            pred_fraction = frac_sum[USEC_W-1:0];
        end
        return pred_total;
    endfunction

    // counter advance between samples, biased towards the interesting ranges
    function automatic logic [SAMPLE_W-1:0] random_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 64'($urandom_range(0, 4_000_000));
        else if (pick < 75)
            return 64'($urandom);
        else if (pick < 85)
            return {$urandom, $urandom};
        else if (pick < 95)
            return 64'($urandom_range(0, 16));
        else
            // straddles the 32-bit saturation boundary
            return 64'h1_0000_0000 + 64'($urandom_range(0, 2)) - 64'd2;
    endfunction

    task automatic log_failure(input string what);
        if (failure_count < 10)
            $display("%s", what);
        failure_count++;
    endtask

    // offer one transaction and hold it until the block takes it; valid is left high
    // so that back-to-back transactions need no second assignment in the same step
    task automatic send_item(input cmd_t cmd, input logic [SAMPLE_W-1:0] count);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.command        <= cmd;
        in_ch.counter_sample <= count;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_usec_q.push_back(advance_usec_total(cmd, count));
    endtask

    // stop offering and wait for every outstanding result; the block is idle after this
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_usec_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only ever issued after drain_results
    task automatic write_tick_frequency(input logic [FREQ_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        pred_freq         = value;
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    // one second of ticks at the reset frequency, straight out of reset with no start
    task automatic test_reset_state();
        send_item(CMD_SAMPLE, 64'd3_579_545);
        send_item(CMD_SAMPLE, 64'd3_579_545);
        drain_results();
    endtask

    // counter wrap, saturation at and past 32 bits, zero difference, field extremes
    task automatic test_wrap_and_clamp();
        logic [SAMPLE_W-1:0] count;
        count = '1;
        send_item(CMD_START, count);
        count = count + 64'd6;                  // wraps to 5
        send_item(CMD_SAMPLE, count);
        count = count + 64'hFFFF_FFFF;          // largest difference that is not clamped
        send_item(CMD_SAMPLE, count);
        count = count + 64'h1_0000_0000;        // smallest difference that is clamped
        send_item(CMD_SAMPLE, count);
        count = 64'h8000_0000_0000_0000;
        send_item(CMD_SAMPLE, count);
        send_item(CMD_SAMPLE, count);           // no ticks since last sample
        send_item(CMD_START, '0);
        send_item(CMD_SAMPLE, '1);
        drain_results();
    endtask

    // frequency at its extremes, at zero, and changed under a live fraction
    task automatic test_frequency_extremes();
        logic [SAMPLE_W-1:0] count;
        // frequency of one: the quotient overflows 32 bits
        write_tick_frequency(32'd1);
        count = '0;
        send_item(CMD_START, count);
        count = count + 64'hFFFF_FFFF;
        send_item(CMD_SAMPLE, count);
        count = count + 64'h1_0000_0000;
        send_item(CMD_SAMPLE, count);
        drain_results();
        // largest frequency: remainders near the divisor, so the fraction sum needs 33 bits
        write_tick_frequency('1);
        send_item(CMD_START, count);
        repeat (3)
        begin
            count = count + 64'hFFFF_FFFE;
            send_item(CMD_SAMPLE, count);
        end
        drain_results();
        // zero frequency: total held, sample still latched
        write_tick_frequency('0);
        count = count + 64'd1000;
        send_item(CMD_SAMPLE, count);
        count = count + 64'd5;
        send_item(CMD_SAMPLE, count);
        drain_results();
        // tiny frequency with the fraction kept from above, already past the divisor
        write_tick_frequency(32'd7);
        count = count + 64'd3;
        send_item(CMD_SAMPLE, count);
        count = count + 64'd1;
        send_item(CMD_SAMPLE, count);
        drain_results();
    endtask

    // bulk of the run: mostly running counter sequences under a range of frequencies
    task automatic test_random_traffic();
        logic [FREQ_W-1:0]   freq;
        logic [SAMPLE_W-1:0] count;
        int unsigned         pick;
        count = {$urandom, $urandom};
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:       freq = FREQ_RESET;
                1:       freq = 32'd1;
                2:       freq = '1;
                3:       freq = 32'd1_000_000;
                4:       freq = 32'd32_768;
                5:       freq = '0;
                6, 7:    freq = 32'($urandom_range(1, 100));
                default: freq = $urandom;
            endcase
            drain_results();
            write_tick_frequency(freq);
            // odd phases carry the fraction across the frequency change
            if (phase % 2 == 0)
            begin
                count = {$urandom, $urandom};
                send_item(CMD_START, count);
            end
            for (int n = 0; n < 120; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    count = {$urandom, $urandom};
                    send_item(CMD_START, count);
                end
                else if (pick < 10)
                begin
                    // unrelated sample, any bit pattern
                    count = {$urandom, $urandom};
                    send_item(CMD_SAMPLE, count);
                end
                else if (pick < 13)
                begin
                    // park just below the top so the following steps wrap
                    count = '1 - 64'($urandom_range(0, 1000));
                    send_item(CMD_SAMPLE, count);
                end
                else
                begin
                    count = count + random_step();
                    send_item(CMD_SAMPLE, count);
                end
            end
        end
        drain_results();
    endtask

    // receiver holds off while samples keep coming, so the block fills and stalls its input
    task automatic test_output_backpressure();
        logic [SAMPLE_W-1:0] count;
        drain_results();
        write_tick_frequency(FREQ_RESET);
        count     = {$urandom, $urandom};
        hold_left = HOLD_CYCLES;
        send_item(CMD_START, count);
        for (int n = 0; n < 14; n++)
        begin
            count = count + random_step();
            send_item(CMD_SAMPLE, count);
        end
        // sender pauses here until every result is back
        drain_results();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_streaming_no_idle();
        logic [SAMPLE_W-1:0] count;
        idle_on = 1'b0;
        drain_results();
        write_tick_frequency(32'd3_000_000 + 32'($urandom_range(0, 1_000_000)));
        count = {$urandom, $urandom};
        send_item(CMD_START, count);
        for (int n = 0; n < 80; n++)
        begin
            count = count + random_step();
            send_item(CMD_SAMPLE, count);
        end
        drain_results();
    endtask

    // receiver: random stall bursts, plus the long hold-off on request
    initial
    begin : result_sink
        int burst_left;
        burst_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                out_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_ch.ready <= 1'b0;
                burst_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                burst_left    = $urandom_range(0, 7);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // every accepted result is matched against the oldest outstanding total
    always @(posedge clk)
    begin : usec_checker
        logic [USEC_W-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_usec_q.size() == 0)
                log_failure($sformatf("unexpected result: microseconds %0d",
                                      out_ch.microseconds));
            else
            begin
                want = expected_usec_q.pop_front();
                if (out_ch.microseconds !== want)
                    log_failure($sformatf("mismatch: microseconds expected %0d got %0d",
                                          want, out_ch.microseconds));
            end
        end
    end

    // watchdog on transactions, not on total run time
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        // inputs known from time zero, reset held low before the tests start
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_START;
        in_ch.counter_sample = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_wrap_and_clamp();
        test_frequency_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_streaming_no_idle();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failure_count == 0 && expected_usec_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
